// ===== rtl/pre_pkg.sv =====
// shared types and constants of the periodic rotation engine
package pre_pkg;

    localparam int unsigned CompW  = 32;
    localparam int unsigned CoefW  = 16;
    localparam int unsigned RowW   = 48;
    localparam int unsigned ShiftW = 32;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned FracSh = 14;

    typedef enum logic [1:0] {
        MODE_POINT  = 2'd0,
        MODE_VECTOR = 2'd1,
        MODE_FULL   = 2'd2,
        MODE_SYM    = 2'd3
    } t_mode;

    localparam logic [CfgIdxW-1:0] REG_ROW_X   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ROW_Y   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_ROW_Z   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SHIFT_X = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_SHIFT_Y = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_SHIFT_Z = 3'd5;

    typedef struct packed {
        logic [1:0]              mode;
        logic signed [CompW-1:0] comp_0;
        logic signed [CompW-1:0] comp_1;
        logic signed [CompW-1:0] comp_2;
        logic signed [CompW-1:0] comp_3;
        logic signed [CompW-1:0] comp_4;
        logic signed [CompW-1:0] comp_5;
        logic signed [CompW-1:0] comp_6;
        logic signed [CompW-1:0] comp_7;
        logic signed [CompW-1:0] comp_8;
    } t_in_word;

    typedef struct packed {
        logic [1:0]              out_mode;
        logic signed [CompW-1:0] res_0;
        logic signed [CompW-1:0] res_1;
        logic signed [CompW-1:0] res_2;
        logic signed [CompW-1:0] res_3;
        logic signed [CompW-1:0] res_4;
        logic signed [CompW-1:0] res_5;
        logic signed [CompW-1:0] res_6;
        logic signed [CompW-1:0] res_7;
        logic signed [CompW-1:0] res_8;
    } t_out_word;

endpackage

// ===== rtl/pre_dot3.sv =====
// pipelined three-term dot product with shift by 14 and optional add
module pre_dot3 #(
    parameter int unsigned COMP_WIDTH = 32,
    parameter int unsigned COEF_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic signed [COEF_WIDTH-1:0] i_m0,
    input  logic signed [COEF_WIDTH-1:0] i_m1,
    input  logic signed [COEF_WIDTH-1:0] i_m2,
    input  logic signed [COMP_WIDTH-1:0] i_a0,
    input  logic signed [COMP_WIDTH-1:0] i_a1,
    input  logic signed [COMP_WIDTH-1:0] i_a2,
    input  logic signed [COMP_WIDTH-1:0] i_add,
    output logic signed [COMP_WIDTH-1:0] o_res
);
    import pre_pkg::*;

    localparam int unsigned PW = COMP_WIDTH + COEF_WIDTH;
    localparam int unsigned SW = PW + 2;
    localparam int unsigned TW = SW + 1;

    logic signed [PW-1:0] r_p0, r_p1, r_p2;
    logic signed [COMP_WIDTH-1:0] r_add1, r_add2;
    logic signed [SW-1:0] r_sum;
    logic signed [TW-1:0] n_tot;
    logic signed [COMP_WIDTH-1:0] n_res;

    localparam logic signed [TW-1:0] Hi = TW'(signed'({1'b0, {(COMP_WIDTH-1){1'b1}}}));
    localparam logic signed [TW-1:0] Lo = -Hi - TW'(1);

    always_ff @(posedge i_clk) begin
        r_p0   <= PW'(i_m0) * PW'(i_a0);
        r_p1   <= PW'(i_m1) * PW'(i_a1);
        r_p2   <= PW'(i_m2) * PW'(i_a2);
        r_add1 <= i_add;
        r_sum  <= SW'(r_p0) + SW'(r_p1) + SW'(r_p2);
        r_add2 <= r_add1;
        o_res  <= n_res;
    end

    always_comb begin
        // arithmetic shift floors, then translation, then one saturation
        n_tot = TW'(r_sum >>> FracSh) + TW'(r_add2);
        if (n_tot > Hi) begin
            n_res = Hi[COMP_WIDTH-1:0];
        end else if (n_tot < Lo) begin
            n_res = Lo[COMP_WIDTH-1:0];
        end else begin
            n_res = n_tot[COMP_WIDTH-1:0];
        end
    end

endmodule

// ===== rtl/pre_stage.sv =====
// one bank of nine dot products: out[a][b] = sum_k m[a][k] * x[b][k], shifted, plus add[a] for b = 0
module pre_stage #(
    parameter int unsigned COMP_WIDTH = 32,
    parameter int unsigned COEF_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic signed [COEF_WIDTH-1:0] i_m   [3][3],
    input  logic signed [COMP_WIDTH-1:0] i_x   [3][3],
    input  logic signed [COMP_WIDTH-1:0] i_add [3],
    output logic signed [COMP_WIDTH-1:0] o_y   [3][3]
);
    import pre_pkg::*;

    for (genvar a = 0; a < 3; a++) begin : g_a
        for (genvar b = 0; b < 3; b++) begin : g_b
            pre_dot3 #(.COMP_WIDTH(COMP_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_dot (
                .i_clk (i_clk),
                .i_m0  (i_m[a][0]),
                .i_m1  (i_m[a][1]),
                .i_m2  (i_m[a][2]),
                .i_a0  (i_x[b][0]),
                .i_a1  (i_x[b][1]),
                .i_a2  (i_x[b][2]),
                .i_add ((b == 0) ? i_add[a] : '0),
                .o_res (o_y[a][b])
            );
        end
    end

endmodule

// ===== rtl/periodic_rotation_engine_core.sv =====
// top level of the periodic rotation engine
// One word enters per cycle (i_start while o_busy is low; o_busy is always
// low) and its result leaves on o_res_word with o_done high after passing
// through the first bank of nine dot products, the second bank and one
// output register. Results cannot be stalled, so there is no back pressure.
// Points and vectors take the first bank only and are delayed to line up
// with tensors. Configuration writes take effect on the next cycle and must
// only happen while no word is in flight.
module periodic_rotation_engine_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  pre_pkg::t_in_word          i_word,
    output logic                       o_done,
    output pre_pkg::t_out_word         o_res_word,
    input  logic                       i_cfg_we,
    input  logic [pre_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [pre_pkg::RowW-1:0]   i_cfg_data
);
    import pre_pkg::*;

    localparam int unsigned Lat = 7;
    localparam int unsigned DotLat = 3;

    logic [RowW-1:0] r_row [3];
    logic signed [ShiftW-1:0] r_shift [3];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0]   <= RowW'(48'd16384);
            r_row[1]   <= RowW'(48'd16384) << 16;
            r_row[2]   <= RowW'(48'd16384) << 32;
            r_shift[0] <= '0;
            r_shift[1] <= '0;
            r_shift[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROW_X:   r_row[0]   <= i_cfg_data;
                REG_ROW_Y:   r_row[1]   <= i_cfg_data;
                REG_ROW_Z:   r_row[2]   <= i_cfg_data;
                REG_SHIFT_X: r_shift[0] <= i_cfg_data[ShiftW-1:0];
                REG_SHIFT_Y: r_shift[1] <= i_cfg_data[ShiftW-1:0];
                REG_SHIFT_Z: r_shift[2] <= i_cfg_data[ShiftW-1:0];
                default: ;
            endcase
        end
    end

    // coefficient matrix, field j of a row at bit 16j
    logic signed [CoefW-1:0] w_m [3][3];
    for (genvar r = 0; r < 3; r++) begin : g_mr
        for (genvar c = 0; c < 3; c++) begin : g_mc
            assign w_m[r][c] = r_row[r][16*c +: CoefW];
        end
    end

    // first bank input: tensor rows, or the vector in row 0
    logic signed [CompW-1:0] w_t [3][3];
    logic signed [CompW-1:0] w_add [3];
    logic [1:0] w_mode;
    assign w_mode = i_word.mode;

    always_comb begin
        w_t[0][0] = i_word.comp_0;
        w_t[0][1] = i_word.comp_1;
        w_t[0][2] = i_word.comp_2;
        if (w_mode == MODE_SYM) begin
            w_t[1][1] = i_word.comp_1;
            w_t[2][2] = i_word.comp_2;
            w_t[0][1] = i_word.comp_3;
            w_t[1][0] = i_word.comp_3;
            w_t[1][2] = i_word.comp_4;
            w_t[2][1] = i_word.comp_4;
            w_t[0][2] = i_word.comp_5;
            w_t[2][0] = i_word.comp_5;
        end else begin
            w_t[1][0] = i_word.comp_3;
            w_t[1][1] = i_word.comp_4;
            w_t[1][2] = i_word.comp_5;
            w_t[2][0] = i_word.comp_6;
            w_t[2][1] = i_word.comp_7;
            w_t[2][2] = i_word.comp_8;
        end
        for (int k = 0; k < 3; k++) begin
            w_add[k] = (w_mode == MODE_POINT) ? r_shift[k] : '0;
        end
    end

    // bank one: u1[j][k] = m[j] . t[k], i.e. u[k][j]
    logic signed [CompW-1:0] w_u1 [3][3];
    pre_stage #(.COMP_WIDTH(CompW), .COEF_WIDTH(CoefW)) u_stage1 (
        .i_clk (i_clk),
        .i_m   (w_m),
        .i_x   (w_t),
        .i_add (w_add),
        .o_y   (w_u1)
    );

    // bank two: r[i][j] = m[i] . column j of u = m[i] . w_u1[j][*]
    logic signed [CompW-1:0] w_r [3][3];
    logic signed [CompW-1:0] w_zero [3];
    assign w_zero = '{default: '0};
    pre_stage #(.COMP_WIDTH(CompW), .COEF_WIDTH(CoefW)) u_stage2 (
        .i_clk (i_clk),
        .i_m   (w_m),
        .i_x   (w_u1),
        .i_add (w_zero),
        .o_y   (w_r)
    );

    // vector results of bank one wait for bank two
    logic signed [CompW-1:0] r_vec [DotLat][3];
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_vec[0][k] <= w_u1[k][0];
        end
        for (int s = 1; s < DotLat; s++) begin
            r_vec[s] <= r_vec[s-1];
        end
    end

    // valid and mode travel with the data
    logic [Lat-2:0] r_vld;
    logic [1:0]     r_mode [Lat-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[Lat-3:0], i_start & ~o_busy};
        end
        r_mode[0] <= w_mode;
        for (int s = 1; s < Lat - 1; s++) begin
            r_mode[s] <= r_mode[s-1];
        end
    end

    // output register
    t_out_word n_out;
    logic [1:0] w_om;
    assign w_om = r_mode[Lat-2];
    always_comb begin
        n_out = '0;
        n_out.out_mode = w_om;
        unique case (w_om)
            MODE_POINT, MODE_VECTOR: begin
                n_out.res_0 = r_vec[DotLat-1][0];
                n_out.res_1 = r_vec[DotLat-1][1];
                n_out.res_2 = r_vec[DotLat-1][2];
            end
            MODE_FULL: begin
                n_out.res_0 = w_r[0][0];
                n_out.res_1 = w_r[0][1];
                n_out.res_2 = w_r[0][2];
                n_out.res_3 = w_r[1][0];
                n_out.res_4 = w_r[1][1];
                n_out.res_5 = w_r[1][2];
                n_out.res_6 = w_r[2][0];
                n_out.res_7 = w_r[2][1];
                n_out.res_8 = w_r[2][2];
            end
            default: begin
                n_out.res_0 = w_r[0][0];
                n_out.res_1 = w_r[1][1];
                n_out.res_2 = w_r[2][2];
                n_out.res_3 = w_r[1][0];
                n_out.res_4 = w_r[2][1];
                n_out.res_5 = w_r[2][0];
            end
        endcase
    end

    logic r_done;
    t_out_word r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld[Lat-2];
        end
        r_out <= n_out;
    end

    assign o_done     = r_done;
    assign o_res_word = r_out;
    assign o_busy     = 1'b0;

endmodule

// ===== rtl/pre_checker.sv =====
// port-level checks of the periodic rotation engine
module pre_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               o_done,
    input pre_pkg::t_in_word  i_word,
    input pre_pkg::t_out_word o_res_word
);
    import pre_pkg::*;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy) else $error("busy raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##7 o_done) else $error("result missing");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, 7)) else $error("result without word");

    a_mode_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##7 (o_res_word.out_mode == $past(i_word.mode, 7)))
        else $error("mode not echoed");

    a_tail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res_word.out_mode != MODE_FULL) |->
        (o_res_word.res_6 == '0 && o_res_word.res_7 == '0 && o_res_word.res_8 == '0))
        else $error("unused result not zero");

endmodule

bind periodic_rotation_engine_core pre_checker u_pre_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_start    (i_start),
    .o_busy     (o_busy),
    .o_done     (o_done),
    .i_word     (i_word),
    .o_res_word (o_res_word)
);
